// File: hw/rtl/ccfe_pkg.sv
// ============================================================================
// Chassis command frame encoder package
// Shared types, frame identifiers and frame-building functions.
// ============================================================================
package ccfe_pkg;

    // Frame identifiers (29-bit extended CAN).
    localparam logic [28:0] ID_IO     = 29'h18C4D7D0;
    localparam logic [28:0] ID_MOTION = 29'h18C4D1D0;
    localparam logic [28:0] ID_FREE   = 29'h18C4D2D0;

    // Gear held after reset.
    localparam logic [3:0] GEAR_RESET = 4'h3;

    // An IO frame follows the motion frame on every IO_PERIOD-th tick.
    localparam int IO_PERIOD = 5;
    localparam int PHASE_W   = (IO_PERIOD > 1) ? $clog2(IO_PERIOD) : 1;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(IO_PERIOD - 1);

    // Depth of the job queue between front and back (a power of two).
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    // Item function codes.
    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_MOTION = 2'd1,
        FUNC_IO     = 2'd2,
        FUNC_FREE   = 2'd3
    } func_t;

    // Input transaction.
    typedef struct packed {
        logic [1:0]         func;
        logic [3:0]         gear;
        logic signed [15:0] linear_speed;
        logic signed [15:0] angular_speed;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic               io_enable;
        logic [4:0]         lamp_bits;
        logic [1:0]         turn_mode;
        logic               speaker_on;
        logic               discharge_on;
        logic               unlock_request;
    } in_item_t;

    // Result transaction.
    typedef struct packed {
        logic [28:0] can_id;
        logic [63:0] payload;
        logic        last;
    } out_item_t;

    // Held lamp and IO command.
    typedef struct packed {
        logic       discharge;
        logic       speaker;
        logic [1:0] turn;
        logic [4:0] lamp;
        logic       enable;
    } io_bits_t;

    // Job passed from the front to the back through the queue.
    typedef struct packed {
        logic        is_free;
        logic        with_io;
        logic [3:0]  gear;
        logic [15:0] speed_a;
        logic [15:0] speed_b;
        io_bits_t    io;
        logic        unlock;
    } job_t;

    // Adds the rolling counter in byte 6 and the XOR check byte in byte 7.
    function automatic logic [63:0] seal(input logic [47:0] body, input logic [3:0] cnt);
        logic [7:0] b6;
        logic [7:0] chk;
        b6  = {cnt, 4'h0};
        chk = body[7:0] ^ body[15:8] ^ body[23:16] ^ body[31:24]
            ^ body[39:32] ^ body[47:40] ^ b6;
        return {chk, b6, body};
    endfunction

    // Motion or free-control frame: gear and two 16-bit speeds on nibble boundaries.
    function automatic logic [63:0] speed_payload(input logic [3:0] gear,
                                                  input logic [15:0] a,
                                                  input logic [15:0] b,
                                                  input logic [3:0] cnt);
        logic [47:0] body;
        body = {8'h00, 4'h0, b[15:12], b[11:4], b[3:0], a[15:12], a[11:4], a[3:0], gear};
        return seal(body, cnt);
    endfunction

    // IO frame built from the held lamp bits and the unlock pulse.
    function automatic logic [63:0] io_payload(input io_bits_t io,
                                               input logic unlock,
                                               input logic [3:0] cnt);
        logic [47:0] body;
        body = {7'h00, io.discharge, 8'h00, 8'h00, 7'h00, io.speaker,
                1'b0, io.lamp[4:2], io.turn, io.lamp[1:0],
                6'h00, unlock, io.enable};
        return seal(body, cnt);
    endfunction

endpackage

// File: hw/rtl/ccfe_queue.sv
// ============================================================================
// Job queue
// Small register queue that decouples the command front from the frame back.
// ============================================================================
module ccfe_queue
    import ccfe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head_job,
    output logic empty
);

    job_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic                do_push;
    logic                do_pop;

    // Status and the oldest entry.
    assign full     = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Storage; entries need no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("job queue count exceeds depth");

    // A lone push grows the queue by one entry.
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("job queue count did not grow on push");

    // The pointers stay a fill count apart.
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (QUEUE_AW'(wr_ptr_reg - rd_ptr_reg) == count_reg[QUEUE_AW-1:0]))
        else $error("job queue pointers disagree with count");

endmodule

// File: hw/rtl/ccfe_front.sv
// ============================================================================
// Command front
// Accepts transactions, holds the latest commands and queues frame jobs.
// ============================================================================
module ccfe_front
    import ccfe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t item,
    input  logic     queue_full,
    output logic     full,
    output logic     job_push,
    output job_t     job
);

    logic [3:0]         held_gear_reg;
    logic [15:0]        held_linear_reg;
    logic [15:0]        held_angular_reg;
    io_bits_t           held_io_reg;
    logic               unlock_pending_reg;
    logic [PHASE_W-1:0] tick_phase_reg;
    logic               accept;
    logic               is_tick;
    logic               is_free;
    logic               with_io;

    // Classification of the incoming transaction.
    assign full    = queue_full;
    assign accept  = push && !queue_full;
    assign is_tick = (func_t'(item.func) == FUNC_TICK);
    assign is_free = (func_t'(item.func) == FUNC_FREE);
    assign with_io = is_tick && (tick_phase_reg == '0);

    // Job snapshot: ticks take the held command, free-control takes the item's own.
    always_comb
    begin
        job.is_free = is_free;
        job.with_io = with_io;
        job.io      = held_io_reg;
        job.unlock  = unlock_pending_reg;
        if (is_free)
        begin
            job.gear    = item.gear;
            job.speed_a = item.left_speed;
            job.speed_b = item.right_speed;
        end
        else
        begin
            job.gear    = held_gear_reg;
            job.speed_a = held_linear_reg;
            job.speed_b = held_angular_reg;
        end
    end

    assign job_push = accept && (is_tick || is_free);

    // Held command state, unlock arming and the IO phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_gear_reg      <= GEAR_RESET;
            held_linear_reg    <= '0;
            held_angular_reg   <= '0;
            held_io_reg        <= '{discharge: 1'b0, speaker: 1'b0, turn: 2'b00,
                                    lamp: 5'b00000, enable: 1'b1};
            unlock_pending_reg <= 1'b0;
            tick_phase_reg     <= '0;
        end
        else if (accept)
        begin
            case (func_t'(item.func))
                FUNC_TICK:
                begin
                    if (with_io)
                    begin
                        unlock_pending_reg <= 1'b0;
                    end
                    if (tick_phase_reg == PHASE_LAST)
                    begin
                        tick_phase_reg <= '0;
                    end
                    else
                    begin
                        tick_phase_reg <= tick_phase_reg + 1'b1;
                    end
                end
                FUNC_MOTION:
                begin
                    held_gear_reg    <= item.gear;
                    held_linear_reg  <= item.linear_speed;
                    held_angular_reg <= item.angular_speed;
                end
                FUNC_IO:
                begin
                    held_io_reg.enable    <= item.io_enable;
                    held_io_reg.lamp      <= item.lamp_bits;
                    held_io_reg.turn      <= item.turn_mode;
                    held_io_reg.speaker   <= item.speaker_on;
                    held_io_reg.discharge <= item.discharge_on;
                    if (item.unlock_request)
                    begin
                        unlock_pending_reg <= 1'b1;
                    end
                end
                default:
                begin
                    // Free-control frames leave the held state alone.
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/ccfe_back.sv
// ============================================================================
// Frame back
// Turns queued jobs into CAN frames and holds them in the output register.
// ============================================================================
module ccfe_back
    import ccfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      job,
    input  logic      job_empty,
    output logic      job_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic [3:0] motion_counter_reg;
    logic [3:0] io_counter_reg;
    logic [3:0] free_counter_reg;
    logic       step_reg;
    logic       out_valid_reg;
    out_item_t  out_reg;
    logic       load;
    out_item_t  frame;
    logic       io_step;

    // A frame is loaded when a job waits and the output register is free.
    assign load    = !job_empty && (!out_valid_reg || pop);
    assign io_step = step_reg;

    // Frame selection and assembly.
    always_comb
    begin
        if (job.is_free)
        begin
            frame.can_id   = ID_FREE;
            frame.payload  = speed_payload(job.gear, job.speed_a, job.speed_b,
                                           free_counter_reg + 4'd1);
            frame.last     = 1'b1;
            job_pop        = load;
        end
        else if (!io_step)
        begin
            frame.can_id   = ID_MOTION;
            frame.payload  = speed_payload(job.gear, job.speed_a, job.speed_b,
                                           motion_counter_reg + 4'd1);
            frame.last     = !job.with_io;
            job_pop        = load && !job.with_io;
        end
        else
        begin
            frame.can_id   = ID_IO;
            frame.payload  = io_payload(job.io, job.unlock, io_counter_reg + 4'd1);
            frame.last     = 1'b1;
            job_pop        = load;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= frame;
        end
    end

    // Rolling counters, step within a tick and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_counter_reg <= '0;
            io_counter_reg     <= '0;
            free_counter_reg   <= '0;
            step_reg           <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                if (job.is_free)
                begin
                    free_counter_reg <= free_counter_reg + 4'd1;
                end
                else if (!io_step)
                begin
                    motion_counter_reg <= motion_counter_reg + 4'd1;
                    step_reg           <= job.with_io;
                end
                else
                begin
                    io_counter_reg <= io_counter_reg + 4'd1;
                    step_reg       <= 1'b0;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    // The IO step only exists for a waiting tick job that carries an IO frame.
    a_step_job: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg |-> (!job_empty && job.with_io && !job.is_free))
        else $error("IO step without a matching tick job");

    // A frame that is not last is always followed by the IO step.
    a_not_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !frame.last) |=> step_reg)
        else $error("non-final frame not followed by IO step");

    // Loading in the IO step presents an IO frame.
    a_io_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (load && step_reg) |=> (out_reg.can_id == ID_IO && out_reg.last))
        else $error("IO step produced a wrong frame");

endmodule

// File: hw/rtl/chassis_command_frame_encoder.sv
// ============================================================================
// Chassis command frame encoder
// Holds motion and lamp commands and emits CAN motion, IO and free frames.
// ============================================================================
//
//  Channel   Handshake            Payload
//  input     push / full          item   (in_item_t)
//  result    empty / pop          result (out_item_t)
//
// A tick yields one motion frame, and on every fifth tick a following IO
// frame; such a tick loads the output register with the motion frame and then
// the IO frame. Command updates produce no frame.
// The output register and the job queue let input continue while a frame
// waits to be popped; full rises only when the queue is full.
// Reset restores the held commands and counters at once; no clearing pass.
//
module chassis_command_frame_encoder
    import ccfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic queue_full;
    logic queue_empty;
    logic job_push;
    logic job_pop;
    job_t in_job;
    job_t head_job;

    // Command front.
    ccfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (item),
        .queue_full (queue_full),
        .full       (full),
        .job_push   (job_push),
        .job        (in_job)
    );

    // Job queue.
    ccfe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (in_job),
        .full     (queue_full),
        .pop      (job_pop),
        .head_job (head_job),
        .empty    (queue_empty)
    );

    // Frame back.
    ccfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (head_job),
        .job_empty (queue_empty),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// File: tb/tb_chassis_command_frame_encoder.sv
// ----------------------------------------------------------------------------
// Testbench for the chassis command frame encoder
// Drives ticks, motion and IO command updates and free-control requests
// through the input queue. It rebuilds every motion, IO and free-control frame
// in a local model of the encoder and checks each popped frame, field by
// field, against the oldest frame still awaited. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_chassis_command_frame_encoder;

    timeunit 1ns;
    timeprecision 1ps;

    import ccfe_pkg::*;

    localparam int MAX_CYCLES   = 1_000_000;
    localparam int RANDOM_ITEMS = 1900;
    localparam int DRAIN_CYCLES = 20;

    // A directed row: the item, and up to two frames typed in by hand.
    typedef struct packed {
        in_item_t   it;
        logic [1:0] n_typed;
        out_item_t  exp0;
        out_item_t  exp1;
    } stim_row_t;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      full;
    in_item_t  item  = '0;
    logic      empty;
    logic      pop   = 1'b0;
    out_item_t result;

    // Local copy of the encoder state.
    logic [3:0]  hold_gear;
    logic [15:0] hold_linear;
    logic [15:0] hold_angular;
    io_bits_t    hold_io;
    logic        unlock_armed;
    int          tick_phase;
    logic [3:0]  cnt_motion;
    logic [3:0]  cnt_io;
    logic [3:0]  cnt_free;

    out_item_t   pending_frames[$];
    stim_row_t   directed_rows[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    logic        send_calm = 1'b0;
    logic        pop_calm = 1'b0;
    int          pop_hold = 0;

    chassis_command_frame_encoder DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Adds the rolling counter and the XOR check byte to a six-byte body.
    function automatic logic [63:0] close_frame(input logic [5:0][7:0] body,
                                                input logic [3:0] cnt);
        logic [7:0] b6;
        logic [7:0] chk;
        b6  = {cnt, 4'h0};
        chk = b6;
        for (int i = 0; i < 6; i++)
        begin
            chk = chk ^ body[i];
        end
        return {chk, b6, body};
    endfunction

    // Gear and two speeds split on nibble boundaries over bytes 0 to 4.
    function automatic logic [63:0] speed_frame_word(input logic [3:0] g,
                                                     input logic [15:0] a,
                                                     input logic [15:0] b,
                                                     input logic [3:0] cnt);
        logic [5:0][7:0] body;
        body    = '0;
        body[0] = {a[3:0], g};
        body[1] = a[11:4];
        body[2] = {b[3:0], a[15:12]};
        body[3] = b[11:4];
        body[4] = {4'h0, b[15:12]};
        return close_frame(body, cnt);
    endfunction

    function automatic out_item_t make_frame(input logic [28:0] id, input logic [63:0] word,
                                             input logic is_last);
        out_item_t f;
        f.can_id   = id;
        f.payload  = word;
        f.last     = is_last;
        return f;
    endfunction

    // Advances the local state by one item and returns the frames it yields.
    task automatic encode_frames(input in_item_t it, output out_item_t f0,
                                 output out_item_t f1, output int n);
        logic             with_io;
        logic [5:0][7:0]  body;
        f0 = '0;
        f1 = '0;
        n  = 0;
        case (func_t'(it.func))
            FUNC_TICK:
            begin
                with_io    = (tick_phase == 0);
                cnt_motion = cnt_motion + 4'd1;
                f0 = make_frame(ID_MOTION,
                                speed_frame_word(hold_gear, hold_linear, hold_angular,
                                                 cnt_motion),
                                !with_io);
                n = 1;
                tick_phase = (tick_phase == IO_PERIOD - 1) ? 0 : tick_phase + 1;
                if (with_io)
                begin
                    body    = '0;
                    body[0] = {6'h00, unlock_armed, hold_io.enable};
                    body[1] = {1'b0, hold_io.lamp[4:2], hold_io.turn, hold_io.lamp[1:0]};
                    body[2] = {7'h00, hold_io.speaker};
                    body[5] = {7'h00, hold_io.discharge};
                    unlock_armed = 1'b0;
                    cnt_io = cnt_io + 4'd1;
                    f1 = make_frame(ID_IO, close_frame(body, cnt_io), 1'b1);
                    n  = 2;
                end
            end
            FUNC_MOTION:
            begin
                hold_gear    = it.gear;
                hold_linear  = it.linear_speed;
                hold_angular = it.angular_speed;
            end
            FUNC_IO:
            begin
                hold_io.enable    = it.io_enable;
                hold_io.lamp      = it.lamp_bits;
                hold_io.turn      = it.turn_mode;
                hold_io.speaker   = it.speaker_on;
                hold_io.discharge = it.discharge_on;
                // A request arms the pulse; an update without one leaves it armed.
                if (it.unlock_request)
                begin
                    unlock_armed = 1'b1;
                end
            end
            default:
            begin
                cnt_free = cnt_free + 4'd1;
                f0 = make_frame(ID_FREE,
                                speed_frame_word(it.gear, it.left_speed, it.right_speed,
                                                 cnt_free),
                                1'b1);
                n = 1;
            end
        endcase
    endtask

    // An item with every field random, so that unused fields carry noise.
    function automatic in_item_t noise_item(input func_t f);
        in_item_t it;
        it.func           = f;
        it.gear           = 4'($urandom_range(0, 15));
        it.linear_speed   = 16'($urandom);
        it.angular_speed  = 16'($urandom);
        it.left_speed     = 16'($urandom);
        it.right_speed    = 16'($urandom);
        it.io_enable      = 1'($urandom_range(0, 1));
        it.lamp_bits      = 5'($urandom_range(0, 31));
        it.turn_mode      = 2'($urandom_range(0, 3));
        it.speaker_on     = 1'($urandom_range(0, 1));
        it.discharge_on   = 1'($urandom_range(0, 1));
        it.unlock_request = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic in_item_t motion_item(input logic [3:0] g, input logic [15:0] lin,
                                             input logic [15:0] ang);
        in_item_t it;
        it               = noise_item(FUNC_MOTION);
        it.gear          = g;
        it.linear_speed  = lin;
        it.angular_speed = ang;
        return it;
    endfunction

    function automatic in_item_t io_item(input logic en, input logic [4:0] lamp,
                                         input logic [1:0] turn, input logic spk,
                                         input logic dis, input logic unl);
        in_item_t it;
        it                = noise_item(FUNC_IO);
        it.io_enable      = en;
        it.lamp_bits      = lamp;
        it.turn_mode      = turn;
        it.speaker_on     = spk;
        it.discharge_on   = dis;
        it.unlock_request = unl;
        return it;
    endfunction

    function automatic in_item_t free_item(input logic [3:0] g, input logic [15:0] l,
                                           input logic [15:0] r);
        in_item_t it;
        it             = noise_item(FUNC_FREE);
        it.gear        = g;
        it.left_speed  = l;
        it.right_speed = r;
        return it;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Speeds lean towards the extremes and the sign boundary.
    function automatic logic [15:0] pick_speed();
        case ($urandom_range(0, 19))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       r;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            it = noise_item(FUNC_TICK);
        end
        else if (r < 60)
        begin
            it = motion_item(4'($urandom_range(0, 15)), pick_speed(), pick_speed());
        end
        else if (r < 80)
        begin
            it = noise_item(FUNC_IO);
        end
        else
        begin
            it = free_item(4'($urandom_range(0, 15)), pick_speed(), pick_speed());
        end
        return it;
    endfunction

    task automatic add_row(input in_item_t it, input logic [1:0] nt,
                           input out_item_t e0, input out_item_t e1);
        stim_row_t row;
        row.it      = it;
        row.n_typed = nt;
        row.exp0    = e0;
        row.exp1    = e1;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Offers one transaction and records the frames it should yield.
    task automatic send_item(input in_item_t it, input logic [1:0] nt,
                             input out_item_t e0, input out_item_t e1);
        int        gap;
        int        n;
        out_item_t f0;
        out_item_t f1;
        gap = send_calm ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        encode_frames(it, f0, f1, n);
        // Hand-typed frames replace the computed ones where a row has them.
        if (nt != 2'd0)
        begin
            f0 = e0;
            f1 = e1;
            n  = int'(nt);
        end
        if (n > 0)
        begin
            pending_frames.insert(pending_frames.size(), f0);
        end
        if (n > 1)
        begin
            pending_frames.insert(pending_frames.size(), f1);
        end
    endtask

    // Compares one popped frame with the oldest awaited frame.
    task automatic check_frame(input out_item_t got);
        out_item_t want;
        if (pending_frames.size() == 0)
        begin
            $error("unexpected frame: can_id %h payload %h last %b",
                   got.can_id, got.payload, got.last);
            fail_count++;
        end
        else
        begin
            want = pending_frames.pop_front();
            if (got.can_id !== want.can_id)
            begin
                $error("can_id mismatch: expected %h, actual %h",
                       want.can_id, got.can_id);
                fail_count++;
            end
            if (got.payload !== want.payload)
            begin
                $error("payload mismatch: expected %h, actual %h", want.payload, got.payload);
                fail_count++;
            end
            if (got.last !== want.last)
            begin
                $error("last mismatch: expected %b, actual %b", want.last, got.last);
                fail_count++;
            end
        end
    endtask

    // Result side: each popped transaction is checked at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            check_frame(result);
        end
    end

    // Result side: pop with random stalls, and calm stretches without any.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 599) == 0)
        begin
            pop_calm = !pop_calm;
        end
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold--;
        end
        else
        begin
            pop <= 1'b1;
            if (!pop_calm && $urandom_range(0, 99) < 35)
            begin
                pop_hold = pick_gap();
            end
        end
    end

    // Watchdog on the length of the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus: directed rows first, then random transactions.
    initial
    begin
        int        left_in_stretch;
        out_item_t none;
        none         = '0;
        hold_gear    = GEAR_RESET;
        hold_linear  = '0;
        hold_angular = '0;
        hold_io      = '0;
        hold_io.enable = 1'b1;
        unlock_armed = 1'b0;
        tick_phase   = 0;
        cnt_motion   = '0;
        cnt_io       = '0;
        cnt_free     = '0;

        // First tick after reset: reset gear, zero speeds, then the IO frame.
        add_row(noise_item(FUNC_TICK), 2'd2,
                make_frame(ID_MOTION, 64'h1310_0000_0000_0003, 1'b0),
                make_frame(ID_IO, 64'h1110_0000_0000_0001, 1'b1));
        // Free-control frames at the speed extremes.
        add_row(free_item(4'hF, 16'h7FFF, 16'h8000), 2'd1,
                make_frame(ID_FREE, 64'h1F10_0008_0007_FFFF, 1'b1), none);
        add_row(free_item(4'h0, 16'hFFFF, 16'hFFFF), 2'd1,
                make_frame(ID_FREE, 64'h2020_000F_FFFF_FFF0, 1'b1), none);
        add_row(motion_item(4'hF, 16'h7FFF, 16'h8000), 2'd0, none, none);
        add_row(noise_item(FUNC_TICK), 2'd0, none, none);
        // Unlock requested, then an update without one keeps the pulse armed.
        add_row(io_item(1'b1, 5'h1F, 2'd3, 1'b1, 1'b1, 1'b1), 2'd0, none, none);
        add_row(io_item(1'b0, 5'h00, 2'd0, 1'b0, 1'b0, 1'b0), 2'd0, none, none);
        add_row(motion_item(4'h0, 16'h8000, 16'h7FFF), 2'd0, none, none);
        repeat (4)
        begin
            add_row(noise_item(FUNC_TICK), 2'd0, none, none);
        end
        add_row(io_item(1'b1, 5'h0A, 2'd2, 1'b0, 1'b1, 1'b0), 2'd0, none, none);
        add_row(motion_item(4'h9, 16'hFFFF, 16'h0001), 2'd0, none, none);
        // Five ticks bring round the next IO frame and wrap the phase.
        repeat (5)
        begin
            add_row(noise_item(FUNC_TICK), 2'd0, none, none);
        end
        add_row(free_item(4'h3, 16'h8000, 16'h7FFF), 2'd0, none, none);
        add_row(io_item(1'b0, 5'h15, 2'd1, 1'b1, 1'b0, 1'b1), 2'd0, none, none);
        add_row(motion_item(4'h6, 16'h0000, 16'h0000), 2'd0, none, none);
        add_row(noise_item(FUNC_TICK), 2'd0, none, none);

        // Reset stays low, then is released at a falling edge.
        repeat (2)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].it, directed_rows[i].n_typed,
                      directed_rows[i].exp0, directed_rows[i].exp1);
        end

        // Random transactions, with stretches where the sender never idles.
        left_in_stretch = $urandom_range(50, 200);
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (left_in_stretch == 0)
            begin
                send_calm       = ($urandom_range(0, 3) == 0);
                left_in_stretch = $urandom_range(50, 200);
            end
            left_in_stretch--;
            send_item(random_item(), 2'd0, none, none);
        end
        @(negedge clk);
        push <= 1'b0;

        // Wait for every awaited frame, then watch for strays.
        while (pending_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end

        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/ccfe_pkg.sv
hw/rtl/ccfe_queue.sv
hw/rtl/ccfe_front.sv
hw/rtl/ccfe_back.sv
hw/rtl/chassis_command_frame_encoder.sv
tb/tb_chassis_command_frame_encoder.sv
